### hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: list size,
// field widths, operation codes and the classified operation record.
// ----------------------------------------------------------------------------
package ple_pkg;

    // list size and derived widths
    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 2;
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // operation queue between front and back
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = 48;

    // operation codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

    // classified operation, as handed from front to back
    typedef struct packed {
        logic              is_insert;
        logic              is_remove;
        logic              is_read;
        logic              is_find;
        logic              pos_zero;
        logic [POS_W-1:0]  pos_m1;
        logic [DATA_W-1:0] value;
    } op_t;

    // one result item
    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  found_position;
        logic [POS_W-1:0]  count;
        logic              empty_res;
    } res_t;

endpackage

### hdl/ple_front.sv
// ----------------------------------------------------------------------------
// ple_front
// Input stage: takes a transfer from the input stream, decodes the action
// and precomputes the zero-based position, then offers it to the queue.
// ----------------------------------------------------------------------------
module ple_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ple_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                       push,
    output ple_pkg::op_t               push_op,
    input  logic                       q_ready
);
    import ple_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    op_t     op_reg;
    op_t     op_next;
    logic    take;
    action_t act;
    logic [POS_W-1:0] pos;

    // input handshake
    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;
    assign push     = valid_reg && q_ready;
    assign push_op  = op_reg;

    assign act = action_t'(s_tuser);
    assign pos = s_tdata[POS_W-1:0];

    // classify the incoming operation
    always_comb begin
        op_next           = op_reg;
        op_next.is_insert = 1'b0;
        op_next.is_remove = 1'b0;
        op_next.is_read   = 1'b0;
        op_next.is_find   = 1'b0;
        case (act)
            ACT_INSERT: op_next.is_insert = 1'b1;
            ACT_REMOVE: op_next.is_remove = 1'b1;
            ACT_READ:   op_next.is_read   = 1'b1;
            ACT_FIND:   op_next.is_find   = 1'b1;
            default:    op_next.is_find   = 1'b1;
        endcase
        op_next.pos_zero = (pos == '0);
        op_next.pos_m1   = pos - POS_W'(1);
        op_next.value    = s_tdata[POS_W +: DATA_W];
    end

    // stage valid
    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg <= op_next;
        end
    end

endmodule

### hdl/ple_queue.sv
// ----------------------------------------------------------------------------
// ple_queue
// Short first-in first-out queue of classified operations that decouples
// the front stage from the list cells.
// ----------------------------------------------------------------------------
module ple_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  ple_pkg::op_t push_op,
    output logic         q_ready,
    output logic         q_valid,
    output ple_pkg::op_t q_op,
    input  logic         pop
);
    import ple_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;

    assign q_ready = (fill_reg != QCNT_W'(QDEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### hdl/ple_cells.sv
// ----------------------------------------------------------------------------
// ple_cells
// Back end: a row of shifting cells with parallel compare. Each operation
// taken from the queue inserts, removes, reads or searches and leaves its
// result in the output register.
// ----------------------------------------------------------------------------
module ple_cells (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ple_pkg::op_t                  q_op,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    logic [DATA_W-1:0] cell_reg  [CAPACITY];
    logic [DATA_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pm1_x;
    logic              full;
    logic              ins_ok;
    logic              at_ok;
    logic              rmv_ok;
    logic              rd_ok;
    logic [DATA_W-1:0] elem_sel;
    logic              found_hit;
    logic [CNT_W-1:0]  found_num;

    assign pop = q_valid && (!m_valid_reg || m_tready);

    // range checks
    assign cnt_x  = CMP_W'(count_reg);
    assign pm1_x  = CMP_W'(q_op.pos_m1);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok = q_op.is_insert && !q_op.pos_zero && (pm1_x <= cnt_x) && !full;
    assign at_ok  = !q_op.pos_zero && (pm1_x < cnt_x);
    assign rmv_ok = q_op.is_remove && at_ok;
    assign rd_ok  = q_op.is_read && at_ok;

    // positional read mux
    always_comb begin
        elem_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) == pm1_x) begin
                elem_sel = cell_reg[i];
            end
        end
    end

    // parallel compare, lowest matching position wins
    always_comb begin
        found_hit = 1'b0;
        found_num = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if ((cell_reg[i] == q_op.value) && (CMP_W'(i) < cnt_x)) begin
                found_hit = 1'b1;
                found_num = CNT_W'(i + 1);
            end
        end
    end

    // cell shifting
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
            if (ins_ok) begin
                if (CMP_W'(i) == pm1_x) begin
                    cell_next[i] = q_op.value;
                end else if (CMP_W'(i) > pm1_x) begin
                    cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (rmv_ok) begin
                if (CMP_W'(i) >= pm1_x) begin
                    cell_next[i] = cell_reg[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    // count and result
    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rmv_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
        res_next.ok             = ins_ok || rmv_ok || rd_ok || (q_op.is_find && found_hit);
        res_next.element        = (rmv_ok || rd_ok) ? elem_sel : '0;
        res_next.found_position = (q_op.is_find && found_hit) ? POS_W'(found_num) : '0;
        res_next.count          = POS_W'(count_next);
        res_next.empty_res      = (count_next == '0);
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                count_reg <= count_next;
            end
        end
    end

    // cells and result payload, no reset
    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < CAPACITY; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            res_reg <= res_next;
        end
    end

    // output packing, ok in the lowest bit
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({res_reg.empty_res, res_reg.count,
                                  res_reg.found_position, res_reg.element, res_reg.ok});

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(count_reg))
        else $error("list count changed without an operation");

    a_count_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && ins_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    a_fail_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.ok) |-> (res_reg.element == '0))
        else $error("failed operation returned an element");

    a_pop_ins_rmv: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !(ins_ok && rmv_ok))
        else $error("insert and remove both qualified");

endmodule

### hdl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values with 1-based insert, remove, read
// and find, one result transfer per input transfer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser: action; s_tdata: position, value
//  m_       out  m_tvalid/m_tready  m_tdata: ok, element, found_position,
//                                            count, empty_res
//
// One item per cycle sustained while m_tready stays high; each operation
// passes through the front register, a queue entry and the result register
// before m_tvalid rises.
// Reset is synchronous, active low; it empties the list and the queue.
// Output stalls fill the queue and then back-pressure the input side.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position [4:0], value [36:5], zero fill above
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  logic [ple_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ok [0], element [32:1], found_position [37:33], count [42:38],
    // empty_res [43], zero fill above
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    logic push;
    op_t  push_op;
    logic q_ready;
    logic q_valid;
    op_t  q_op;
    logic pop;

    // decode stage
    ple_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_op  (push_op),
        .q_ready  (q_ready)
    );

    // operation queue
    ple_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop)
    );

    // cell row and result register
    ple_cells u_cells (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
